FILE: rtl/key_press_fsm_bcd_counter_assert.svh
// assertion macros for the key press counter block
`ifndef KEY_PRESS_FSM_BCD_COUNTER_ASSERT_SVH
`define KEY_PRESS_FSM_BCD_COUNTER_ASSERT_SVH
`ifndef SYNTHESIS
`define KPB_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("key press counter assertion failed");
`define KPB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("key press counter invariant failed");
`else
`define KPB_ASSERT(lbl, clk, rstn, prop)
`define KPB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: rtl/kpbcd_pkg.sv
// shared types, codes and helpers for the key press counter
package kpbcd_pkg;

  localparam int KEY_W   = 4;
  localparam int TICK_W  = 16;
  localparam int DIGIT_W = 4;
  localparam int EVENT_W = 2;
  localparam int CFG_IDX_W = 1;

  typedef logic [DIGIT_W-1:0] bcd_digit_t;
  typedef bcd_digit_t [3:0] bcd_word_t;

  localparam logic [KEY_W-1:0] KEY_NONE     = 4'd0;
  localparam logic [KEY_W-1:0] KEY_COUNT    = 4'd1;
  localparam logic [KEY_W-1:0] KEY_HUNDREDS = 4'd2;

  localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
  localparam logic [EVENT_W-1:0] EV_SHORT  = 2'd1;
  localparam logic [EVENT_W-1:0] EV_REPEAT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT     = 1'd1;

  localparam logic [TICK_W-1:0] LONG_PRESS_RESET = 16'd100;
  localparam logic [TICK_W-1:0] REPEAT_RESET     = 16'd20;

  localparam bcd_digit_t DIGIT_MAX = 4'd9;
  localparam bcd_word_t  DIGITS_RESET = {4'd2, 4'd0, 4'd1, 4'd0};

  // add one at the ones or the hundreds digit, carry upward, clear on overflow
  function automatic bcd_word_t bcd_bump(input bcd_word_t d, input logic from_hundreds);
    bcd_word_t r;
    logic      carry;
    r = d;
    carry = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (carry && ((i >= 2) || !from_hundreds)) begin
        if (d[i] == DIGIT_MAX) begin
          r[i] = '0;
        end else begin
          r[i] = d[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (carry) begin
      r = '0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/key_press_fsm_bcd_counter.sv
// latency: a key sample transferred at one edge gives its result on the outputs after that edge
// throughput: one key sample per clock cycle while in_stall_o is low, set by the single press state register update
// the result register is the only output buffer; input stalls only while it is full and stalled
// reset: press state idle, no held key, hold count zero, digits show 2010
// reset: long press count 100, repeat count 20, no result pending
`include "key_press_fsm_bcd_counter_assert.svh"
module key_press_fsm_bcd_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [kpbcd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [kpbcd_pkg::TICK_W-1:0]      cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kpbcd_pkg::KEY_W-1:0]       key_code_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kpbcd_pkg::DIGIT_W-1:0]     digit_ones_o,
  output logic [kpbcd_pkg::DIGIT_W-1:0]     digit_tens_o,
  output logic [kpbcd_pkg::DIGIT_W-1:0]     digit_hundreds_o,
  output logic [kpbcd_pkg::DIGIT_W-1:0]     digit_thousands_o,
  output logic [kpbcd_pkg::EVENT_W-1:0]     key_event_o
);
  import kpbcd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DOWN = 2'd1,
    ST_TIME = 2'd2,
    ST_LONG = 2'd3
  } press_e;

  press_e              state_q, state_d;
  logic [KEY_W-1:0]    held_key_q, held_key_d;
  logic [TICK_W-1:0]   hold_q, hold_d, hold_inc;
  bcd_word_t           digits_q, digits_d;
  logic [EVENT_W-1:0]  event_q, event_d;
  logic [TICK_W-1:0]   long_press_q, repeat_q;
  logic                out_valid_q;
  logic                in_acc, out_acc, act;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;
  assign hold_inc   = hold_q + 16'd1;

  always_comb begin
    state_d    = state_q;
    held_key_d = held_key_q;
    hold_d     = hold_q;
    event_d    = EV_NONE;
    act        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (key_code_i != KEY_NONE) state_d = ST_DOWN;
      end
      ST_DOWN: begin
        if (key_code_i == KEY_NONE) begin
          state_d = ST_IDLE;
        end else begin
          state_d    = ST_TIME;
          hold_d     = '0;
          held_key_d = key_code_i;
        end
      end
      ST_TIME: begin
        if (key_code_i == KEY_NONE) begin
          state_d = ST_IDLE;
          act     = 1'b1;
          event_d = EV_SHORT;
        end else if (key_code_i != held_key_q) begin
          state_d = ST_DOWN;
        end else if (hold_inc == long_press_q) begin
          hold_d  = '0;
          state_d = ST_LONG;
        end else begin
          hold_d = hold_inc;
        end
      end
      ST_LONG: begin
        if (key_code_i == KEY_NONE) begin
          state_d = ST_IDLE;
        end else if (key_code_i != held_key_q) begin
          state_d = ST_DOWN;
        end else if (hold_inc == repeat_q) begin
          hold_d  = '0;
          act     = 1'b1;
          event_d = EV_REPEAT;
        end else begin
          hold_d = hold_inc;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    digits_d = digits_q;
    if (act && (held_key_q == KEY_COUNT)) begin
      digits_d = bcd_bump(digits_q, 1'b0);
    end else if (act && (held_key_q == KEY_HUNDREDS)) begin
      digits_d = bcd_bump(digits_q, 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LONG_PRESS_RESET;
      repeat_q     <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LONG_PRESS: long_press_q <= cfg_data_i;
        REG_REPEAT:     repeat_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_key_q  <= KEY_NONE;
      hold_q      <= '0;
      digits_q    <= DIGITS_RESET;
      event_q     <= EV_NONE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q    <= state_d;
        held_key_q <= held_key_d;
        hold_q     <= hold_d;
        digits_q   <= digits_d;
        event_q    <= event_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign digit_ones_o      = digits_q[0];
  assign digit_tens_o      = digits_q[1];
  assign digit_hundreds_o  = digits_q[2];
  assign digit_thousands_o = digits_q[3];
  assign key_event_o       = event_q;

  `KPB_ASSERT(a_short_on_release, clk_i, rst_ni, (in_acc && state_q == ST_TIME && key_code_i == KEY_NONE) |=> (event_q == EV_SHORT && state_q == ST_IDLE))
  `KPB_ASSERT(a_long_release_silent, clk_i, rst_ni, (in_acc && state_q == ST_LONG && key_code_i == KEY_NONE) |=> (event_q == EV_NONE && state_q == ST_IDLE))
  `KPB_ASSERT(a_stall_needs_result, clk_i, rst_ni, in_stall_o |-> out_valid_q)
  `KPB_ASSERT(a_digits_hold_idle, clk_i, rst_ni, !in_acc |=> $stable(digits_q))
  `KPB_ASSERT(a_digits_bcd, clk_i, rst_ni, (digits_q[0] <= DIGIT_MAX && digits_q[1] <= DIGIT_MAX && digits_q[2] <= DIGIT_MAX && digits_q[3] <= DIGIT_MAX))
  `KPB_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == ST_IDLE && !out_valid_q))

endmodule
